FILE: sv/slas_pkg.sv
// Package for the status LED animation sequencer: codes, control word and flag types,
// microcode program table. No dependencies.
`timescale 1ns / 1ps

package slas_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int PC_W       = 6;
	localparam int DIV_W      = 25;
	localparam int MOD_STEPS  = 17;
	localparam int TRI_STEPS  = 8;
	localparam int DIV_CNT_W  = 5;
	localparam logic [1:0] DOOR_PULSES = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BREATHE_PERIOD = 3'd0,
		CFG_DOOR_PERIOD    = 3'd1,
		CFG_ERR_PULSE      = 3'd2,
		CFG_ERR_GAP        = 3'd3,
		CFG_ERR_PAIR_GAP   = 3'd4,
		CFG_IDLE_PEAK      = 3'd5
	} slas_cfg_idx_t;

	typedef enum logic [2:0] {
		ERR_IDLE     = 3'd0,
		ERR_PULSE1   = 3'd1,
		ERR_GAP      = 3'd2,
		ERR_PULSE2   = 3'd3,
		ERR_PAIR_GAP = 3'd4
	} slas_err_step_t;

	typedef enum logic [1:0] {
		DOOR_OFF     = 2'd0,
		DOOR_PULSING = 2'd1,
		DOOR_SOLID   = 2'd2
	} slas_door_step_t;

	typedef enum logic [1:0] {
		SPAN_FIRST = 2'd0,
		SPAN_CLEAR = 2'd1,
		SPAN_ALL   = 2'd2
	} slas_span_t;

	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2
	} slas_chan_t;

	typedef enum logic [1:0] {
		MODE_DARK  = 2'd0,
		MODE_IDLE  = 2'd1,
		MODE_ERROR = 2'd2
	} slas_mode_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_TIME_ADD, OP_DOOR_CLR, OP_EMIT_DARK, OP_DOOR_INIT, OP_DOOR_SUM,
		OP_DIV_MOD, OP_DOOR_WRAP, OP_DOOR_NOWRAP, OP_TRI_DOOR, OP_EMIT_SOLID,
		OP_ERR_INIT, OP_ERR_SINCE, OP_ERR_PAIR_CHK, OP_ERR_GAP_CHK, OP_TRI_ERR,
		OP_ERR_PULSE_END, OP_BR_SUM, OP_BR_WRAP, OP_BR_NOWRAP, OP_TRI_BR,
		OP_TRI_MUL, OP_DIV_TRI, OP_EMIT_TRI
	} slas_op_t;

	typedef enum logic [3:0] {
		C_NEXT, C_ALWAYS, C_NO_TICK, C_DT_ZERO, C_DOOR, C_MODE_ERR, C_MODE_IDLE,
		C_DOOR_SOLID, C_SUM_LT_PER, C_DIV_BUSY, C_ERR_PULSE, C_ERR_GAP, C_SINCE_GE_PULSE
	} slas_cond_t;

	typedef struct packed {
		slas_op_t          op;
		slas_cond_t        cond;
		logic              emit;
		logic [PC_W-1:0]   target;
	} slas_uword_t;

	typedef struct packed {
		slas_op_t op;
		logic     exec;
		logic     emit;
		logic     idle;
	} slas_ctrl_t;

	typedef struct packed {
		logic tick_valid;
		logic out_busy;
		logic dt_zero;
		logic door;
		logic mode_err;
		logic mode_idle;
		logic door_solid;
		logic sum_lt_per;
		logic div_busy;
		logic err_pulse;
		logic err_gap;
		logic since_ge_pulse;
	} slas_flags_t;

	// program labels
	localparam logic [PC_W-1:0] L_IDLE          = 6'd0;
	localparam logic [PC_W-1:0] L_DOOR          = 6'd6;
	localparam logic [PC_W-1:0] L_DOOR_DIV_WAIT = 6'd10;
	localparam logic [PC_W-1:0] L_DOOR_NOWRAP   = 6'd12;
	localparam logic [PC_W-1:0] L_DOOR_TAIL     = 6'd13;
	localparam logic [PC_W-1:0] L_DOOR_SOLID    = 6'd15;
	localparam logic [PC_W-1:0] L_ERR           = 6'd16;
	localparam logic [PC_W-1:0] L_ERR_PULSE     = 6'd21;
	localparam logic [PC_W-1:0] L_ERR_PULSE_END = 6'd23;
	localparam logic [PC_W-1:0] L_ERR_GAP       = 6'd24;
	localparam logic [PC_W-1:0] L_BR            = 6'd25;
	localparam logic [PC_W-1:0] L_BR_DIV_WAIT   = 6'd28;
	localparam logic [PC_W-1:0] L_BR_NOWRAP     = 6'd30;
	localparam logic [PC_W-1:0] L_BR_TRI        = 6'd31;
	localparam logic [PC_W-1:0] L_TRI           = 6'd32;
	localparam logic [PC_W-1:0] L_TRI_WAIT      = 6'd34;

	function automatic slas_uword_t mk(input slas_op_t op, input slas_cond_t cond,
			input logic emit, input logic [PC_W-1:0] target);
		slas_uword_t w;
		w.op     = op;
		w.cond   = cond;
		w.emit   = emit;
		w.target = target;
		return w;
	endfunction

	function automatic slas_uword_t ucode(input logic [PC_W-1:0] pc);
		slas_uword_t w;
		case (pc)
			6'd0:  w = mk(OP_NOP,           C_NO_TICK,        1'b0, L_IDLE);
			6'd1:  w = mk(OP_TIME_ADD,      C_DT_ZERO,        1'b0, L_IDLE);
			6'd2:  w = mk(OP_NOP,           C_DOOR,           1'b0, L_DOOR);
			6'd3:  w = mk(OP_DOOR_CLR,      C_MODE_ERR,       1'b0, L_ERR);
			6'd4:  w = mk(OP_NOP,           C_MODE_IDLE,      1'b0, L_BR);
			6'd5:  w = mk(OP_EMIT_DARK,     C_ALWAYS,         1'b1, L_IDLE);
			// door open
			6'd6:  w = mk(OP_DOOR_INIT,     C_DOOR_SOLID,     1'b0, L_DOOR_SOLID);
			6'd7:  w = mk(OP_DOOR_SUM,      C_NEXT,           1'b0, L_IDLE);
			6'd8:  w = mk(OP_NOP,           C_SUM_LT_PER,     1'b0, L_DOOR_NOWRAP);
			6'd9:  w = mk(OP_DIV_MOD,       C_NEXT,           1'b0, L_IDLE);
			6'd10: w = mk(OP_NOP,           C_DIV_BUSY,       1'b0, L_DOOR_DIV_WAIT);
			6'd11: w = mk(OP_DOOR_WRAP,     C_ALWAYS,         1'b0, L_DOOR_TAIL);
			6'd12: w = mk(OP_DOOR_NOWRAP,   C_NEXT,           1'b0, L_IDLE);
			6'd13: w = mk(OP_NOP,           C_DOOR_SOLID,     1'b0, L_DOOR_SOLID);
			6'd14: w = mk(OP_TRI_DOOR,      C_ALWAYS,         1'b0, L_TRI);
			6'd15: w = mk(OP_EMIT_SOLID,    C_ALWAYS,         1'b1, L_IDLE);
			// error
			6'd16: w = mk(OP_ERR_INIT,      C_NEXT,           1'b0, L_IDLE);
			6'd17: w = mk(OP_ERR_SINCE,     C_NEXT,           1'b0, L_IDLE);
			6'd18: w = mk(OP_NOP,           C_ERR_PULSE,      1'b0, L_ERR_PULSE);
			6'd19: w = mk(OP_NOP,           C_ERR_GAP,        1'b0, L_ERR_GAP);
			6'd20: w = mk(OP_ERR_PAIR_CHK,  C_ALWAYS,         1'b0, L_IDLE);
			6'd21: w = mk(OP_NOP,           C_SINCE_GE_PULSE, 1'b0, L_ERR_PULSE_END);
			6'd22: w = mk(OP_TRI_ERR,       C_ALWAYS,         1'b0, L_TRI);
			6'd23: w = mk(OP_ERR_PULSE_END, C_ALWAYS,         1'b1, L_IDLE);
			6'd24: w = mk(OP_ERR_GAP_CHK,   C_ALWAYS,         1'b0, L_IDLE);
			// idle breathing
			6'd25: w = mk(OP_BR_SUM,        C_NEXT,           1'b0, L_IDLE);
			6'd26: w = mk(OP_NOP,           C_SUM_LT_PER,     1'b0, L_BR_NOWRAP);
			6'd27: w = mk(OP_DIV_MOD,       C_NEXT,           1'b0, L_IDLE);
			6'd28: w = mk(OP_NOP,           C_DIV_BUSY,       1'b0, L_BR_DIV_WAIT);
			6'd29: w = mk(OP_BR_WRAP,       C_ALWAYS,         1'b0, L_BR_TRI);
			6'd30: w = mk(OP_BR_NOWRAP,     C_NEXT,           1'b0, L_IDLE);
			6'd31: w = mk(OP_TRI_BR,        C_ALWAYS,         1'b0, L_TRI);
			// shared triangle level
			6'd32: w = mk(OP_TRI_MUL,       C_NEXT,           1'b0, L_IDLE);
			6'd33: w = mk(OP_DIV_TRI,       C_NEXT,           1'b0, L_IDLE);
			6'd34: w = mk(OP_NOP,           C_DIV_BUSY,       1'b0, L_TRI_WAIT);
			6'd35: w = mk(OP_EMIT_TRI,      C_ALWAYS,         1'b1, L_IDLE);
			default: w = mk(OP_NOP,         C_ALWAYS,         1'b0, L_IDLE);
		endcase
		return w;
	endfunction

endpackage

FILE: sv/slas_if.sv
// Handshake channels of the status LED animation sequencer: tick input, frame output,
// configuration write. Depends on slas_pkg.
`timescale 1ns / 1ps

interface slas_tick_if;
	logic        valid;
	logic        ready;
	logic [15:0] elapsed_ms;
	logic        door_open;
	logic [1:0]  device_mode;
	modport source (output valid, elapsed_ms, door_open, device_mode, input ready);
	modport sink (input valid, elapsed_ms, door_open, device_mode, output ready);
endinterface

interface slas_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [1:0] span;
	modport source (output valid, red, green, blue, span, input ready);
	modport sink (input valid, red, green, blue, span, output ready);
endinterface

interface slas_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [slas_pkg::CFG_IDX_W-1:0]  index;
	logic [slas_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/status_led_animation_sequencer_core.sv
// Status LED animation sequencer: one tick item in, at most one frame item out.
// Each accepted tick emits solid green, dark, an error pulse end or a triangle level, or no
// frame; a wrapping phase first takes a 17-step modulo in the serial divider, which also divides the level.
// A new tick is taken only at the idle step; a full frame register holds the emitting step.
// Reset (arst_n low, asynchronous) clears the time base and sequence state and loads
// the register defaults.
`timescale 1ns / 1ps

module status_led_animation_sequencer_core (
	input  logic          clk,
	input  logic          arst_n,
	slas_tick_if.sink     tick,
	slas_frame_if.source  frame,
	slas_cfg_if.sink      cfg
);

	slas_pkg::slas_ctrl_t  ctrl;
	slas_pkg::slas_flags_t flags;

	slas_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	slas_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.flags  (flags),
		.tick   (tick),
		.frame  (frame),
		.cfg    (cfg)
	);

`ifndef ASSERT_OFF
	a_idle_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.idle |-> !flags.div_busy)
		else $error("divider busy while waiting for a tick");

	a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.exec && ctrl.emit) |-> !(frame.valid && !frame.ready))
		else $error("frame written while output register full");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(tick.valid && tick.ready) |=> !tick.ready)
		else $error("sequencer stayed idle after taking a tick");
`endif

endmodule

FILE: sv/slas_divider.sv
// Shared restoring divider, one quotient bit per cycle: 17-step modulo or 8-step
// triangle level. Depends on slas_pkg.
`timescale 1ns / 1ps

module slas_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        tri_mode,
	input  logic [slas_pkg::DIV_W-1:0]  dividend,
	input  logic [15:0]                 divisor,
	output logic                        busy,
	output logic [7:0]                  quot,
	output logic [15:0]                 rem
);

	logic [slas_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [slas_pkg::DIV_W-1:0]     sh_q;
	logic [15:0]                    rem_q;
	logic [15:0]                    div_q;
	logic [7:0]                     quot_q;
	logic [16:0]                    trial;
	logic [16:0]                    diff;
	logic                           ge;

	assign trial = {rem_q, sh_q[slas_pkg::DIV_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= tri_mode ? slas_pkg::DIV_CNT_W'(slas_pkg::TRI_STEPS)
			                  : slas_pkg::DIV_CNT_W'(slas_pkg::MOD_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q  <= divisor;
			quot_q <= '0;
			if (tri_mode) begin
				// quotient stays below 256, so the upper part is already a remainder
				rem_q <= dividend[23:8];
				sh_q  <= {dividend[7:0], 17'b0};
			end else begin
				rem_q <= '0;
				sh_q  <= {dividend[16:0], 8'b0};
			end
		end else if (cnt_q != '0) begin
			rem_q  <= ge ? diff[15:0] : trial[15:0];
			quot_q <= {quot_q[6:0], ge};
			sh_q   <= {sh_q[slas_pkg::DIV_W-2:0], 1'b0};
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

FILE: sv/slas_sequencer.sv
// Microcode sequencer: step counter, program table lookup, conditional jumps, output stall.
// Depends on slas_pkg.
`timescale 1ns / 1ps

module slas_sequencer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  slas_pkg::slas_flags_t  flags,
	output slas_pkg::slas_ctrl_t   ctrl
);

	logic [slas_pkg::PC_W-1:0] pc_q;
	slas_pkg::slas_uword_t     word;
	logic                      take;
	logic                      stall;

	assign word = slas_pkg::ucode(pc_q);

	always_comb begin
		case (word.cond)
			slas_pkg::C_NEXT:           take = 1'b0;
			slas_pkg::C_ALWAYS:         take = 1'b1;
			slas_pkg::C_NO_TICK:        take = !flags.tick_valid;
			slas_pkg::C_DT_ZERO:        take = flags.dt_zero;
			slas_pkg::C_DOOR:           take = flags.door;
			slas_pkg::C_MODE_ERR:       take = flags.mode_err;
			slas_pkg::C_MODE_IDLE:      take = flags.mode_idle;
			slas_pkg::C_DOOR_SOLID:     take = flags.door_solid;
			slas_pkg::C_SUM_LT_PER:     take = flags.sum_lt_per;
			slas_pkg::C_DIV_BUSY:       take = flags.div_busy;
			slas_pkg::C_ERR_PULSE:      take = flags.err_pulse;
			slas_pkg::C_ERR_GAP:        take = flags.err_gap;
			slas_pkg::C_SINCE_GE_PULSE: take = flags.since_ge_pulse;
			default:                    take = 1'b0;
		endcase
	end

	// hold an emitting step while the output register is still full
	assign stall = word.emit && flags.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= slas_pkg::L_IDLE;
		end else if (!stall) begin
			pc_q <= take ? word.target : pc_q + 1'b1;
		end
	end

	assign ctrl.op   = word.op;
	assign ctrl.exec = !stall;
	assign ctrl.emit = word.emit;
	assign ctrl.idle = pc_q == slas_pkg::L_IDLE;

endmodule

FILE: sv/slas_datapath.sv
// Datapath: configuration registers, sequence state, working registers, output register.
// Depends on slas_pkg, slas_if and slas_divider.
`timescale 1ns / 1ps

module slas_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  slas_pkg::slas_ctrl_t  ctrl,
	output slas_pkg::slas_flags_t flags,
	slas_tick_if.sink             tick,
	slas_frame_if.source          frame,
	slas_cfg_if.sink              cfg
);

	// configuration
	logic [15:0] breathe_period_q;
	logic [15:0] door_period_q;
	logic [15:0] err_pulse_q;
	logic [15:0] err_gap_q;
	logic [15:0] err_pair_gap_q;
	logic [7:0]  idle_peak_q;

	// sequence state
	logic [31:0]               time_q;
	slas_pkg::slas_err_step_t  err_step_q;
	logic [31:0]               err_start_q;
	slas_pkg::slas_door_step_t door_step_q;
	logic [15:0]               door_phase_q;
	logic [1:0]                door_pulses_q;
	logic [15:0]               breathe_phase_q;

	// item and working registers
	logic [15:0]              dt_q;
	logic                     door_q;
	logic [1:0]               mode_q;
	logic [16:0]              sum_q;
	logic [15:0]              per_q;
	logic [31:0]              since_q;
	logic [15:0]              pval_q;
	logic [7:0]               peak_q;
	slas_pkg::slas_chan_t     chan_q;
	slas_pkg::slas_span_t     span_q;
	logic [slas_pkg::DIV_W-1:0] num_q;

	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;
	logic [1:0] out_span_q;
	logic       out_valid_q;

	logic        accept;
	logic        fire;
	logic        div_start;
	logic        div_busy;
	logic [7:0]  div_quot;
	logic [15:0] div_rem;
	logic [15:0] door_per;
	logic [15:0] breathe_per;
	logic        tri_lo;
	logic [15:0] tri_arg;
	logic [23:0] prod;
	logic [1:0]  pulses_inc;

	assign accept      = tick.valid && ctrl.idle;
	assign tick.ready  = ctrl.idle;
	assign cfg.ready   = 1'b1;
	assign fire        = ctrl.exec && ctrl.emit;
	assign door_per    = (door_period_q == 16'd0) ? 16'd1 : door_period_q;
	assign breathe_per = (breathe_period_q == 16'd0) ? 16'd1 : breathe_period_q;
	assign tri_lo      = {pval_q, 1'b0} <= {1'b0, per_q};
	assign tri_arg     = tri_lo ? pval_q : per_q - pval_q;
	assign prod        = 24'(peak_q) * 24'(tri_arg);
	assign pulses_inc  = (door_pulses_q == 2'd3) ? door_pulses_q : door_pulses_q + 1'b1;
	assign div_start   = ctrl.exec &&
	                     (ctrl.op == slas_pkg::OP_DIV_MOD || ctrl.op == slas_pkg::OP_DIV_TRI);

	slas_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.tri_mode (ctrl.op == slas_pkg::OP_DIV_TRI),
		.dividend ((ctrl.op == slas_pkg::OP_DIV_TRI) ? num_q : {8'b0, sum_q}),
		.divisor  (per_q),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			breathe_period_q <= 16'd4000;
			door_period_q    <= 16'd600;
			err_pulse_q      <= 16'd200;
			err_gap_q        <= 16'd200;
			err_pair_gap_q   <= 16'd1000;
			idle_peak_q      <= 8'd200;
		end else if (cfg.valid) begin
			case (cfg.index)
				slas_pkg::CFG_BREATHE_PERIOD: breathe_period_q <= cfg.data;
				slas_pkg::CFG_DOOR_PERIOD:    door_period_q    <= cfg.data;
				slas_pkg::CFG_ERR_PULSE:      err_pulse_q      <= cfg.data;
				slas_pkg::CFG_ERR_GAP:        err_gap_q        <= cfg.data;
				slas_pkg::CFG_ERR_PAIR_GAP:   err_pair_gap_q   <= cfg.data;
				slas_pkg::CFG_IDLE_PEAK:      idle_peak_q      <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dt_q   <= tick.elapsed_ms;
			door_q <= tick.door_open;
			mode_q <= tick.device_mode;
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q          <= '0;
			err_step_q      <= slas_pkg::ERR_IDLE;
			err_start_q     <= '0;
			door_step_q     <= slas_pkg::DOOR_OFF;
			door_phase_q    <= '0;
			door_pulses_q   <= '0;
			breathe_phase_q <= '0;
		end else if (ctrl.exec) begin
			case (ctrl.op)
				slas_pkg::OP_TIME_ADD: time_q <= time_q + {16'b0, dt_q};
				slas_pkg::OP_DOOR_CLR: door_step_q <= slas_pkg::DOOR_OFF;
				slas_pkg::OP_DOOR_INIT: begin
					if (door_step_q == slas_pkg::DOOR_OFF) begin
						door_step_q   <= slas_pkg::DOOR_PULSING;
						door_phase_q  <= '0;
						door_pulses_q <= '0;
					end
				end
				slas_pkg::OP_DOOR_WRAP: begin
					door_phase_q  <= div_rem;
					door_pulses_q <= pulses_inc;
					if (pulses_inc >= slas_pkg::DOOR_PULSES) begin
						door_step_q <= slas_pkg::DOOR_SOLID;
					end
				end
				slas_pkg::OP_DOOR_NOWRAP: door_phase_q <= sum_q[15:0];
				slas_pkg::OP_ERR_INIT: begin
					if (!(err_step_q inside {slas_pkg::ERR_PULSE1, slas_pkg::ERR_GAP,
					                         slas_pkg::ERR_PULSE2, slas_pkg::ERR_PAIR_GAP})) begin
						err_step_q  <= slas_pkg::ERR_PULSE1;
						err_start_q <= time_q;
					end
				end
				slas_pkg::OP_ERR_PAIR_CHK: begin
					if (since_q >= {16'b0, err_pair_gap_q}) begin
						err_step_q  <= slas_pkg::ERR_PULSE1;
						err_start_q <= time_q;
					end
				end
				slas_pkg::OP_ERR_GAP_CHK: begin
					if (since_q >= {16'b0, err_gap_q}) begin
						err_step_q  <= slas_pkg::ERR_PULSE2;
						err_start_q <= time_q;
					end
				end
				slas_pkg::OP_ERR_PULSE_END: begin
					err_step_q  <= (err_step_q == slas_pkg::ERR_PULSE1) ? slas_pkg::ERR_GAP
					                                                   : slas_pkg::ERR_PAIR_GAP;
					err_start_q <= time_q;
				end
				slas_pkg::OP_BR_WRAP:   breathe_phase_q <= div_rem;
				slas_pkg::OP_BR_NOWRAP: breathe_phase_q <= sum_q[15:0];
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			case (ctrl.op)
				slas_pkg::OP_DOOR_SUM: begin
					sum_q <= {1'b0, door_phase_q} + {1'b0, dt_q};
					per_q <= door_per;
				end
				slas_pkg::OP_BR_SUM: begin
					sum_q <= {1'b0, breathe_phase_q} + {1'b0, dt_q};
					per_q <= breathe_per;
				end
				slas_pkg::OP_ERR_SINCE: since_q <= time_q - err_start_q;
				slas_pkg::OP_TRI_DOOR: begin
					pval_q <= door_phase_q;
					peak_q <= 8'd255;
					chan_q <= slas_pkg::CH_GREEN;
					span_q <= slas_pkg::SPAN_FIRST;
				end
				slas_pkg::OP_TRI_ERR: begin
					pval_q <= since_q[15:0];
					per_q  <= err_pulse_q;
					peak_q <= 8'd255;
					chan_q <= slas_pkg::CH_RED;
					span_q <= slas_pkg::SPAN_ALL;
				end
				slas_pkg::OP_TRI_BR: begin
					pval_q <= breathe_phase_q;
					peak_q <= idle_peak_q;
					chan_q <= slas_pkg::CH_BLUE;
					span_q <= slas_pkg::SPAN_CLEAR;
				end
				slas_pkg::OP_TRI_MUL: num_q <= {prod, 1'b0};
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			case (ctrl.op)
				slas_pkg::OP_EMIT_SOLID: begin
					red_q      <= 8'd0;
					green_q    <= 8'd255;
					blue_q     <= 8'd0;
					out_span_q <= slas_pkg::SPAN_ALL;
				end
				slas_pkg::OP_EMIT_TRI: begin
					red_q      <= (chan_q == slas_pkg::CH_RED) ? div_quot : 8'd0;
					green_q    <= (chan_q == slas_pkg::CH_GREEN) ? div_quot : 8'd0;
					blue_q     <= (chan_q == slas_pkg::CH_BLUE) ? div_quot : 8'd0;
					out_span_q <= span_q;
				end
				default: begin
					red_q      <= 8'd0;
					green_q    <= 8'd0;
					blue_q     <= 8'd0;
					out_span_q <= slas_pkg::SPAN_ALL;
				end
			endcase
		end
	end

	assign frame.valid = out_valid_q;
	assign frame.red   = red_q;
	assign frame.green = green_q;
	assign frame.blue  = blue_q;
	assign frame.span  = out_span_q;

	assign flags.tick_valid     = tick.valid;
	assign flags.out_busy       = out_valid_q && !frame.ready;
	assign flags.dt_zero        = dt_q == 16'd0;
	assign flags.door           = door_q;
	assign flags.mode_err       = mode_q == slas_pkg::MODE_ERROR;
	assign flags.mode_idle      = mode_q == slas_pkg::MODE_IDLE;
	assign flags.door_solid     = door_step_q == slas_pkg::DOOR_SOLID;
	assign flags.sum_lt_per     = sum_q < {1'b0, per_q};
	assign flags.div_busy       = div_busy;
	assign flags.err_pulse      = err_step_q inside {slas_pkg::ERR_PULSE1, slas_pkg::ERR_PULSE2};
	assign flags.err_gap        = err_step_q == slas_pkg::ERR_GAP;
	assign flags.since_ge_pulse = since_q >= {16'b0, err_pulse_q};

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Testbench for status_led_animation_sequencer_core: directed and random ticks over several
// register settings, each frame checked against a behavioral predictor of the sequencer.
// Depends on slas_pkg, the channel interfaces in slas_if.sv and the core RTL.

module tb;
	import slas_pkg::*;

	localparam int unsigned CLK_HALF_NS     = 10;
	localparam int unsigned DRAIN_CYCLES    = 60;
	localparam int unsigned LONG_HOLD       = 500;
	localparam int unsigned LIMIT_CYCLES    = 2_000_000;
	localparam logic [1:0]  MODE_OTHER      = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [15:0] elapsed_ms;
		logic        door_open;
		logic [1:0]  device_mode;
	} tick_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		slas_span_t span;
	} frame_t;

	logic clk;
	logic arst_n;

	slas_tick_if  tick_ch();
	slas_frame_if frame_ch();
	slas_cfg_if   cfg_ch();

	status_led_animation_sequencer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.frame  (frame_ch),
		.cfg    (cfg_ch)
	);

	// register shadow
	int unsigned breathe_per, door_per, pulse_len, gap_len, pair_len, peak;
	// sequence state
	int unsigned     clock_ms, err_start, door_phase, door_count, breathe_phase;
	slas_err_step_t  err_step;
	slas_door_step_t door_step;

	tick_t  send_q[$];
	frame_t frame_q[$];

	int unsigned errors, ticks_accepted, frames_checked, reg_writes;
	int unsigned send_gap, recv_hold;
	bit          steady, long_hold_go;

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF_NS) clk = ~clk;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("frame %0d %s: got %0d, expected %0d", frames_checked, what, got, want);
		errors++;
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (steady || r < 55) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 4);
	endfunction

	function automatic int unsigned ramp_level(input int unsigned p, input int unsigned per,
			input int unsigned pk);
		if (per == 0) return 0;
		if (p > per) p = per;
		if (2 * p <= per) return (2 * pk * p) / per;
		return (2 * pk * (per - p)) / per;
	endfunction

	function automatic void load_defaults();
		breathe_per   = 4000;
		door_per      = 600;
		pulse_len     = 200;
		gap_len       = 200;
		pair_len      = 1000;
		peak          = 200;
		clock_ms      = 0;
		err_start     = 0;
		err_step      = ERR_IDLE;
		door_step     = DOOR_OFF;
		door_phase    = 0;
		door_count    = 0;
		breathe_phase = 0;
	endfunction

	function automatic void predict_tick(input tick_t t);
		int unsigned dt, per, since;
		frame_t      f;
		bit          has;
		dt = 32'(t.elapsed_ms);
		if (dt == 0) return;
		clock_ms += dt;
		has = 1'b1;
		f.red   = 8'd0;
		f.green = 8'd0;
		f.blue  = 8'd0;
		f.span  = SPAN_ALL;
		if (t.door_open) begin
			per = (door_per != 0) ? door_per : 1;
			if (door_step == DOOR_OFF) begin
				door_step  = DOOR_PULSING;
				door_phase = 0;
				door_count = 0;
			end
			f.green = 8'd255;
			if (door_step == DOOR_PULSING) begin
				door_phase += dt;
				if (door_phase >= per) begin
					door_phase %= per;
					if (door_count < 3) door_count++;
					if (door_count >= DOOR_PULSES) door_step = DOOR_SOLID;
				end
				if (door_step == DOOR_PULSING) begin
					f.green = 8'(ramp_level(door_phase, per, 255));
					f.span  = SPAN_FIRST;
				end
			end
		end else begin
			door_step = DOOR_OFF;
			if (t.device_mode == MODE_ERROR) begin
				if (err_step == ERR_IDLE) begin
					err_step  = ERR_PULSE1;
					err_start = clock_ms;
				end
				since = clock_ms - err_start;
				case (err_step)
					ERR_PULSE1, ERR_PULSE2: begin
						if (since >= pulse_len) begin
							err_step  = (err_step == ERR_PULSE1) ? ERR_GAP : ERR_PAIR_GAP;
							err_start = clock_ms;
						end else begin
							f.red = 8'(ramp_level(since, pulse_len, 255));
						end
					end
					ERR_GAP: begin
						has = 1'b0;
						if (since >= gap_len) begin
							err_step  = ERR_PULSE2;
							err_start = clock_ms;
						end
					end
					default: begin
						has = 1'b0;
						if (since >= pair_len) begin
							err_step  = ERR_PULSE1;
							err_start = clock_ms;
						end
					end
				endcase
			end else if (t.device_mode == MODE_IDLE) begin
				per = (breathe_per != 0) ? breathe_per : 1;
				breathe_phase += dt;
				if (breathe_phase >= per) breathe_phase %= per;
				f.blue = 8'(ramp_level(breathe_phase, per, peak));
				f.span = SPAN_CLEAR;
			end
		end
		if (has) frame_q.push_back(f);
	endfunction

	// tick sender
	always @(posedge clk or negedge arst_n) begin
		tick_t nxt;
		if (!arst_n) begin
			tick_ch.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (tick_ch.valid && tick_ch.ready) begin
				predict_tick({tick_ch.elapsed_ms, tick_ch.door_open, tick_ch.device_mode});
				ticks_accepted++;
			end
			if (!tick_ch.valid || tick_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					tick_ch.valid <= 1'b0;
				end else if (send_q.size() > 0) begin
					nxt = send_q.pop_front();
					tick_ch.elapsed_ms  <= nxt.elapsed_ms;
					tick_ch.door_open   <= nxt.door_open;
					tick_ch.device_mode <= nxt.device_mode;
					tick_ch.valid       <= 1'b1;
					send_gap = pick_gap();
				end else begin
					tick_ch.valid <= 1'b0;
				end
			end
		end
	end

	// frame receiver and checker
	always @(posedge clk or negedge arst_n) begin
		frame_t want;
		int unsigned g;
		if (!arst_n) begin
			frame_ch.ready <= 1'b0;
			recv_hold = 0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				if (frame_q.size() == 0) begin
					report_mismatch("unexpected item",
						32'({frame_ch.red, frame_ch.green, frame_ch.blue}), 0);
				end else begin
					want = frame_q.pop_front();
					if (frame_ch.red != want.red)
						report_mismatch("red", 32'(frame_ch.red), 32'(want.red));
					if (frame_ch.green != want.green)
						report_mismatch("green", 32'(frame_ch.green), 32'(want.green));
					if (frame_ch.blue != want.blue)
						report_mismatch("blue", 32'(frame_ch.blue), 32'(want.blue));
					if (frame_ch.span != want.span)
						report_mismatch("span", 32'(frame_ch.span), 32'(want.span));
				end
				frames_checked++;
			end
			if (long_hold_go) begin
				long_hold_go = 1'b0;
				recv_hold = LONG_HOLD;
				frame_ch.ready <= 1'b0;
			end else if (recv_hold > 0) begin
				recv_hold--;
				frame_ch.ready <= 1'b0;
			end else begin
				g = pick_gap();
				if (g == 0) begin
					frame_ch.ready <= 1'b1;
				end else begin
					frame_ch.ready <= 1'b0;
					recv_hold = g - 1;
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		reg_writes++;
		case (idx)
			CFG_BREATHE_PERIOD: breathe_per = 32'(val);
			CFG_DOOR_PERIOD:    door_per    = 32'(val);
			CFG_ERR_PULSE:      pulse_len   = 32'(val);
			CFG_ERR_GAP:        gap_len     = 32'(val);
			CFG_ERR_PAIR_GAP:   pair_len    = 32'(val);
			CFG_IDLE_PEAK:      peak        = 32'(val[7:0]);
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [15:0] br, input logic [15:0] dp, input logic [15:0] pl,
			input logic [15:0] gl, input logic [15:0] pg, input logic [15:0] pk);
		write_reg(CFG_BREATHE_PERIOD, br);
		write_reg(CFG_DOOR_PERIOD, dp);
		write_reg(CFG_ERR_PULSE, pl);
		write_reg(CFG_ERR_GAP, gl);
		write_reg(CFG_ERR_PAIR_GAP, pg);
		write_reg(CFG_IDLE_PEAK, pk);
	endtask

	function automatic logic [15:0] pick_reg();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50) return 16'($urandom_range(3000, 2));
		if (r < 80) return 16'($urandom_range(10, 0));
		return 16'($urandom_range(65535, 0));
	endfunction

	task automatic settle();
		while (!(send_q.size() == 0 && !tick_ch.valid && frame_q.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void push_tick(input logic [15:0] dt, input logic door,
			input logic [1:0] mode);
		tick_t t;
		t.elapsed_ms  = dt;
		t.door_open   = door;
		t.device_mode = mode;
		send_q.push_back(t);
	endfunction

	// episodes of one mode with ticks scaled to the current periods, plus random noise
	function automatic void queue_random(input int unsigned count);
		int unsigned n, run, kind, scale, r, k;
		logic        door;
		logic [1:0]  mode;
		logic [15:0] dt;
		n = 0;
		while (n < count) begin
			kind = $urandom_range(19);
			door = 1'b0;
			mode = 2'($urandom_range(3));
			run  = $urandom_range(30, 1);
			if (kind < 5) begin
				door  = 1'b1;
				scale = door_per / 3 + 1;
			end else if (kind < 10) begin
				mode  = MODE_ERROR;
				scale = (pulse_len + gap_len + pair_len) / 4 + 1;
			end else if (kind < 15) begin
				mode  = MODE_IDLE;
				scale = breathe_per / 5 + 1;
			end else if (kind < 17) begin
				mode  = (kind == 15) ? MODE_DARK : MODE_OTHER;
				scale = 100;
			end else begin
				door  = 1'($urandom_range(1));
				scale = 65535;
				run   = 1;
			end
			if (scale > 65535) scale = 65535;
			for (k = 0; k < run; k++) begin
				r = $urandom_range(99);
				if (r < 4) dt = 16'd0;
				else if (r < 10) dt = 16'($urandom_range(65535, 0));
				else dt = 16'($urandom_range(scale, 1));
				push_tick(dt, door, mode);
				if (dt != 0) n++;
			end
		end
	endfunction

	initial begin
		tick_ch.valid       = 1'b0;
		tick_ch.elapsed_ms  = '0;
		tick_ch.door_open   = 1'b0;
		tick_ch.device_mode = MODE_DARK;
		frame_ch.ready      = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = CFG_BREATHE_PERIOD;
		cfg_ch.data         = '0;
		errors         = 0;
		ticks_accepted = 0;
		frames_checked = 0;
		reg_writes     = 0;
		steady         = 1'b0;
		long_hold_go   = 1'b0;
		load_defaults();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: door pulses to solid, full error cycle, breathing wrap
		push_tick(16'd0, 1'b0, MODE_IDLE);
		push_tick(16'd0, 1'b1, MODE_ERROR);
		push_tick(16'd1, 1'b0, MODE_DARK);
		push_tick(16'd65535, 1'b0, MODE_OTHER);
		push_tick(16'd1000, 1'b0, MODE_IDLE);
		push_tick(16'd1500, 1'b0, MODE_IDLE);
		push_tick(16'd65535, 1'b0, MODE_IDLE);
		push_tick(16'd150, 1'b1, MODE_IDLE);
		push_tick(16'd150, 1'b1, MODE_ERROR);
		push_tick(16'd400, 1'b1, MODE_DARK);
		push_tick(16'd65535, 1'b1, MODE_OTHER);
		push_tick(16'd10, 1'b1, MODE_IDLE);
		push_tick(16'd5, 1'b0, MODE_ERROR);
		push_tick(16'd100, 1'b0, MODE_ERROR);
		push_tick(16'd100, 1'b0, MODE_ERROR);
		push_tick(16'd150, 1'b0, MODE_ERROR);
		push_tick(16'd50, 1'b0, MODE_ERROR);
		push_tick(16'd50, 1'b0, MODE_IDLE);
		push_tick(16'd70, 1'b0, MODE_ERROR);
		push_tick(16'd300, 1'b0, MODE_ERROR);
		push_tick(16'd999, 1'b0, MODE_ERROR);
		push_tick(16'd1, 1'b0, MODE_ERROR);
		push_tick(16'd1, 1'b1, MODE_ERROR);
		push_tick(16'd65535, 1'b0, MODE_OTHER);
		queue_random(300);
		long_hold_go = 1'b1;
		settle();

		// zero periods and lengths, unused register slots
		set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		write_reg(CFG_SPARE_6, 16'($urandom));
		write_reg(CFG_SPARE_7, 16'($urandom));
		queue_random(200);
		settle();

		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		steady = 1'b1;
		queue_random(300);
		settle();
		steady = 1'b0;

		set_regs(16'd2, 16'd1, 16'd1, 16'hFFFF, 16'd0, 16'd255);
		queue_random(300);
		settle();

		set_regs(pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg(),
			16'($urandom_range(255)));
		queue_random(350);
		long_hold_go = 1'b1;
		settle();

		set_regs(pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg(),
			16'($urandom_range(255)));
		queue_random(350);
		settle();

		$display("covered door, error, breathing and dark ticks over six register settings");
		$display("%0d ticks accepted, %0d frames checked, %0d register writes",
			ticks_accepted, frames_checked, reg_writes);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/slas_pkg.sv
sv/slas_if.sv
sv/slas_divider.sv
sv/slas_sequencer.sv
sv/slas_datapath.sv
sv/status_led_animation_sequencer_core.sv
test/tb.sv
